### rtl/core/gdmp_pkg.sv
// ----------------------------------------------------------------------------
// gdmp_pkg
// Shared constants, types and helpers for the gray / dither / mono packer.
// ----------------------------------------------------------------------------
package gdmp_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W     = COL_W + 1;
    localparam int IW_W      = 13;
    localparam int CMP_W     = (CNT_W > IW_W) ? CNT_W : IW_W;

    // output format codes; codes 1 and 3 both give gray bytes
    localparam logic [1:0] FMT_RGB  = 2'd0;
    localparam logic [1:0] FMT_MONO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OUT_FORMAT  = 2'd0;
    localparam logic [1:0] CFG_DIFFUSE     = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd2;

    // q0.16 luma weights
    localparam logic [13:0] GRAY_WR = 14'd13763;
    localparam logic [15:0] GRAY_WG = 16'd47186;
    localparam logic [12:0] GRAY_WB = 13'd4588;

    localparam logic [7:0] MONO_THRESH = 8'd127;
    localparam logic [7:0] MSB_MASK    = 8'h80;

    // line store entry: shares known when column x is processed
    typedef struct packed {
        logic              row_last;
        logic signed [3:0] br;
        logic signed [6:0] bot;
    } line_a_t;

    // bottom-left share, written one column later
    typedef logic signed [5:0] line_b_t;

    typedef struct packed {
        logic signed [3:0] br;
        logic signed [6:0] bot;
        logic signed [5:0] bl;
    } shares_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] x;
        logic             last;
        logic             frame_start;
        logic             rd_ok;
    } px_ctrl_t;

    typedef struct packed {
        logic             a_en;
        logic [COL_W-1:0] a_addr;
        line_a_t          a_data;
        logic             b_en;
        logic [COL_W-1:0] b_addr;
        line_b_t          b_data;
    } line_wr_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] byte_count;
        logic       row_end;
    } result_t;

    // add a signed share to a pixel value and clamp to 0..255
    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic signed [7:0] c);
        logic signed [9:0] s;
        s = $signed({2'b00, v}) + $signed({{2{c[7]}}, c});
        if (s[9])
            return 8'd0;
        else if (s[8])
            return 8'd255;
        else
            return s[7:0];
    endfunction

endpackage

### rtl/core/gray_dither_mono_packer.sv
// ----------------------------------------------------------------------------
// gray_dither_mono_packer
// Raster RGB to RGB, gray or 1-bit packed mono with error diffusion.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the skid entry is free. A pixel passes the
// s1 and s2 registers and then the output register, and results leave one per
// pixel in RGB and gray modes and one per eight pixels (or at row end) in mono
// mode. The rate is set by the diffusion stage, where the right-hand error of
// one pixel is registered and feeds the next, and by the line store, whose two
// memories of MAX_WIDTH entries are read once and written once per pixel.
// Frame start needs no clearing pass: a fill count marks which line entries
// belong to the current frame, so the first pixel of a frame is taken like any
// other. The input stalls only when both the output register and its skid entry are full.
module gray_dither_mono_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // byte0, byte1, byte2, byte_count, zero fill
    output logic        m_axis_tlast,   // row_end
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import gdmp_pkg::*;

    logic [1:0]  out_format_reg;
    logic        diffuse_reg;
    logic [12:0] image_width_reg;

    logic             adv, skid_full, res_valid;
    logic [COL_W-1:0] rd_x;
    px_ctrl_t         s1_ctrl, s2_ctrl;
    line_wr_t         wr;
    shares_t          shares;
    result_t          res, out_res;
    logic [7:0]       s2_gray, s2_red, s2_green, s2_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_format_reg  <= 2'd1;
            diffuse_reg     <= 1'b1;
            image_width_reg <= 13'd640;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_OUT_FORMAT:  out_format_reg  <= cfg_wdata[1:0];
                CFG_DIFFUSE:     diffuse_reg     <= cfg_wdata[0];
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign adv           = !skid_full;
    assign s_axis_tready = adv;

    gdmp_pixel_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_axis_tvalid),
        .red         (s_axis_tdata[7:0]),
        .green       (s_axis_tdata[15:8]),
        .blue        (s_axis_tdata[23:16]),
        .frame_start (s_axis_tuser),
        .image_width (image_width_reg),
        .rd_x        (rd_x),
        .s1_ctrl     (s1_ctrl),
        .s2_ctrl     (s2_ctrl),
        .s2_gray     (s2_gray),
        .s2_red      (s2_red),
        .s2_green    (s2_green),
        .s2_blue     (s2_blue)
    );

    gdmp_line_store u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .rd_x    (rd_x),
        .s1_ctrl (s1_ctrl),
        .wr      (wr),
        .shares  (shares)
    );

    gdmp_err_loop u_loop (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .s2_ctrl    (s2_ctrl),
        .gray       (s2_gray),
        .red        (s2_red),
        .green      (s2_green),
        .blue       (s2_blue),
        .shares     (shares),
        .out_format (out_format_reg),
        .diffuse    (diffuse_reg),
        .wr         (wr),
        .res_valid  (res_valid),
        .result     (res)
    );

    gdmp_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && res_valid),
        .push_data (res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .skid_full (skid_full)
    );

    assign m_axis_tdata = {6'b0, out_res.byte_count, out_res.byte2,
                           out_res.byte1, out_res.byte0};
    assign m_axis_tlast = out_res.row_end;

endmodule

### rtl/core/gdmp_pixel_front.sv
// ----------------------------------------------------------------------------
// gdmp_pixel_front
// Column and fill tracking at the input, luma products and the gray sum.
// ----------------------------------------------------------------------------
module gdmp_pixel_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    input  logic                      frame_start,
    input  logic [12:0]               image_width,
    output logic [gdmp_pkg::COL_W-1:0] rd_x,
    output gdmp_pkg::px_ctrl_t        s1_ctrl,
    output gdmp_pkg::px_ctrl_t        s2_ctrl,
    output logic [7:0]                s2_gray,
    output logic [7:0]                s2_red,
    output logic [7:0]                s2_green,
    output logic [7:0]                s2_blue
);
    import gdmp_pkg::*;

    logic [COL_W-1:0] column_reg, column_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [COL_W-1:0] x_in;
    logic [CNT_W-1:0] fill_base, x_cnt;
    logic [CMP_W-1:0] iw_ext, w_eff, x_plus;
    logic             last_in, rd_ok_in, acc;

    px_ctrl_t s1_ctrl_reg, s2_ctrl_reg;
    logic [21:0] prod_r_reg;
    logic [23:0] prod_g_reg;
    logic [20:0] prod_b_reg;
    logic [7:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [7:0]  s2_red_reg, s2_green_reg, s2_blue_reg, s2_gray_reg;
    logic [23:0] gray_sum;

    always_comb
    begin
        iw_ext = CMP_W'(image_width);
        priority if (iw_ext == '0)
            w_eff = CMP_W'(1);
        else if (iw_ext > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = iw_ext;

        x_in      = frame_start ? '0 : column_reg;
        fill_base = frame_start ? '0 : fill_reg;
        x_plus    = CMP_W'(x_in) + CMP_W'(1);
        last_in   = (x_plus >= w_eff);
        // entries at or above the fill count were not written in this frame
        rd_ok_in  = !frame_start && (CNT_W'(x_in) < fill_reg);

        x_cnt       = CNT_W'(x_in) + CNT_W'(1);
        fill_next   = (x_cnt > fill_base) ? x_cnt : fill_base;
        column_next = last_in ? '0 : x_in + COL_W'(1);
        acc         = adv && in_valid;
        gray_sum    = 24'(prod_r_reg) + prod_g_reg + 24'(prod_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            fill_reg    <= '0;
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                column_reg <= column_next;
                fill_reg   <= fill_next;
            end
            if (adv)
            begin
                s1_ctrl_reg <= '{valid: in_valid, x: x_in, last: last_in,
                                 frame_start: frame_start, rd_ok: rd_ok_in};
                s2_ctrl_reg <= s1_ctrl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_r_reg   <= 22'(red) * 22'(GRAY_WR);
            prod_g_reg   <= 24'(green) * 24'(GRAY_WG);
            prod_b_reg   <= 21'(blue) * 21'(GRAY_WB);
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s2_gray_reg  <= gray_sum[23:16];
            s2_red_reg   <= s1_red_reg;
            s2_green_reg <= s1_green_reg;
            s2_blue_reg  <= s1_blue_reg;
        end
    end

    assign rd_x     = x_in;
    assign s1_ctrl  = s1_ctrl_reg;
    assign s2_ctrl  = s2_ctrl_reg;
    assign s2_gray  = s2_gray_reg;
    assign s2_red   = s2_red_reg;
    assign s2_green = s2_green_reg;
    assign s2_blue  = s2_blue_reg;

`ifndef SYNTH
    a_column_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(column_reg) <= fill_reg)
        else $error("column ahead of line store fill count");
`endif

endmodule

### rtl/core/gdmp_line_store.sv
// ----------------------------------------------------------------------------
// gdmp_line_store
// Previous-row error shares: two 1w1r memories with write forwarding.
// ----------------------------------------------------------------------------
module gdmp_line_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [gdmp_pkg::COL_W-1:0] rd_x,
    input  gdmp_pkg::px_ctrl_t         s1_ctrl,
    input  gdmp_pkg::line_wr_t         wr,
    output gdmp_pkg::shares_t          shares
);
    import gdmp_pkg::*;

    line_a_t mem_a [MAX_WIDTH];
    line_b_t mem_b [MAX_WIDTH];

    line_a_t rd_a_reg, byp_a_data_reg, a1, a_fwd;
    line_b_t rd_b_reg, byp_b_data_reg, b1, b_fwd;
    logic    byp_a_reg, byp_b_reg;
    shares_t shares_reg, shares_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr.a_en)
                mem_a[wr.a_addr] <= wr.a_data;
            if (wr.b_en)
                mem_b[wr.b_addr] <= wr.b_data;
            rd_a_reg       <= mem_a[rd_x];
            rd_b_reg       <= mem_b[rd_x];
            byp_a_data_reg <= wr.a_data;
            byp_b_data_reg <= wr.b_data;
            shares_reg     <= shares_next;
        end
    end

    // write landing on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            byp_a_reg <= wr.a_en && (wr.a_addr == rd_x);
            byp_b_reg <= wr.b_en && (wr.b_addr == rd_x);
        end
    end

    always_comb
    begin
        a1 = byp_a_reg ? byp_a_data_reg : rd_a_reg;
        b1 = byp_b_reg ? byp_b_data_reg : rd_b_reg;
        // write landing while the item waits one stage before the loop
        a_fwd = (wr.a_en && (wr.a_addr == s1_ctrl.x)) ? wr.a_data : a1;
        b_fwd = (wr.b_en && (wr.b_addr == s1_ctrl.x)) ? wr.b_data : b1;
        if (s1_ctrl.rd_ok)
        begin
            shares_next.br  = a_fwd.br;
            shares_next.bot = a_fwd.bot;
            shares_next.bl  = a_fwd.row_last ? '0 : b_fwd;
        end
        else
            shares_next = '0;
    end

    assign shares = shares_reg;

endmodule

### rtl/core/gdmp_err_loop.sv
// ----------------------------------------------------------------------------
// gdmp_err_loop
// Diffusion step, threshold, share generation and mono bit packing.
// ----------------------------------------------------------------------------
module gdmp_err_loop (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  gdmp_pkg::px_ctrl_t s2_ctrl,
    input  logic [7:0]         gray,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  gdmp_pkg::shares_t  shares,
    input  logic [1:0]         out_format,
    input  logic               diffuse,
    output gdmp_pkg::line_wr_t wr,
    output logic               res_valid,
    output gdmp_pkg::result_t  result
);
    import gdmp_pkg::*;

    logic signed [6:0] right_error_reg, re;
    logic signed [3:0] br_carry_reg, brc;
    logic [7:0]        pack_reg, pb, packed_byte;
    logic [2:0]        pos_reg, pos;

    logic              mono, rgb, on, bit_on, emit;
    logic [7:0]        v1, v2, v3, v4, v;
    logic [8:0]        diff;
    logic signed [7:0] err;
    logic signed [10:0] err_x, p7, p5, p3;
    logic signed [6:0] s7, s5;
    logic signed [5:0] s3;
    logic signed [3:0] s1;
    logic              step;

    always_comb
    begin
        mono = (out_format == FMT_MONO);
        rgb  = (out_format == FMT_RGB);
        on   = mono && diffuse;
        re   = s2_ctrl.frame_start ? '0 : right_error_reg;
        brc  = s2_ctrl.frame_start ? '0 : br_carry_reg;
        pb   = s2_ctrl.frame_start ? '0 : pack_reg;
        pos  = s2_ctrl.frame_start ? '0 : pos_reg;

        // clamp after every addition, above-row shares first
        v1 = sat_add(gray, {{4{shares.br[3]}}, shares.br});
        v2 = sat_add(v1, {shares.bot[6], shares.bot});
        v3 = sat_add(v2, {{2{shares.bl[5]}}, shares.bl});
        v4 = sat_add(v3, {re[6], re});
        v  = on ? v4 : gray;

        bit_on = (v > MONO_THRESH);
        diff   = {1'b0, v} - 9'd255;
        if (!on)
            err = '0;
        else if (bit_on)
            err = diff[7:0];
        else
            err = v;

        err_x = {{3{err[7]}}, err};
        p7    = err_x * 11'sd7;
        p5    = err_x * 11'sd5;
        p3    = err_x * 11'sd3;
        // floor shifts by four
        s7    = p7[10:4];
        s5    = p5[10:4];
        s3    = p3[9:4];
        s1    = err[7:4];

        wr.a_en   = s2_ctrl.valid;
        wr.a_addr = s2_ctrl.x;
        wr.a_data = '{row_last: s2_ctrl.last, br: brc, bot: s5};
        wr.b_en   = s2_ctrl.valid && (s2_ctrl.x != '0);
        wr.b_addr = s2_ctrl.x - COL_W'(1);
        wr.b_data = s3;

        packed_byte = pb | (bit_on ? (MSB_MASK >> pos) : 8'h00);
        emit        = !mono || (pos == 3'd7) || s2_ctrl.last;
        res_valid   = s2_ctrl.valid && emit;

        priority if (rgb)
            result.byte0 = red;
        else if (mono)
            result.byte0 = packed_byte;
        else
            result.byte0 = gray;
        result.byte1      = rgb ? green : 8'h00;
        result.byte2      = rgb ? blue : 8'h00;
        result.byte_count = rgb ? 2'd3 : 2'd1;
        result.row_end    = s2_ctrl.last;

        step = adv && s2_ctrl.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_error_reg <= '0;
            br_carry_reg    <= '0;
            pack_reg        <= '0;
            pos_reg         <= '0;
        end
        else if (step)
        begin
            right_error_reg <= s2_ctrl.last ? '0 : s7;
            br_carry_reg    <= s2_ctrl.last ? '0 : s1;
            if (emit)
            begin
                pack_reg <= '0;
                pos_reg  <= '0;
            end
            else
            begin
                pack_reg <= packed_byte;
                pos_reg  <= pos + 3'd1;
            end
        end
    end

`ifndef SYNTH
    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && s2_ctrl.last) |=> (right_error_reg == '0 && br_carry_reg == '0))
        else $error("row end left carried error");
    a_packer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !mono) |=> (pos_reg == '0 && pack_reg == '0))
        else $error("packer not cleared outside mono mode");
`endif

endmodule

### rtl/core/gdmp_out_skid.sv
// ----------------------------------------------------------------------------
// gdmp_out_skid
// Output register with one skid entry toward the result stream.
// ----------------------------------------------------------------------------
module gdmp_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gdmp_pkg::result_t push_data,
    input  logic              out_ready,
    output logic              out_valid,
    output gdmp_pkg::result_t out_data,
    output logic              skid_full
);
    import gdmp_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output item");
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled item not kept in skid entry");
`endif

endmodule

### tb/gdmp_checker.sv
// ----------------------------------------------------------------------------
// gdmp_checker
// Watches the pixel, result and register channels of the gray / dither /
// mono packer, keeps its own model of the line store, the diffusion window
// and the bit packer, and compares every result item with the oldest one due.
// ----------------------------------------------------------------------------
package gdmp_tb_pkg;

    // format codes and register index that the rtl package leaves unnamed
    localparam logic [1:0] FMT_GRAY     = 2'd1;
    localparam logic [1:0] FMT_GRAY_ALT = 2'd3;
    localparam logic [1:0] CFG_SPARE    = 2'd3;

endpackage

module gdmp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_data,     // red, green, blue
    input  logic        s_user,     // frame_start
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_data,     // byte0, byte1, byte2, byte_count, zero fill
    input  logic        m_last,     // row_end
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import gdmp_pkg::*;
    import gdmp_tb_pkg::*;

    localparam int LUMA_R        = 13763;
    localparam int LUMA_G        = 47186;
    localparam int LUMA_B        = 4588;
    localparam int THRESHOLD     = 127;
    localparam int DEFAULT_WIDTH = 640;

    typedef struct packed {
        int br;
        int bot;
        int bl;
    } share_set_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;
        logic       row_end;
    } out_bytes_t;

    logic [1:0]  fmt;
    logic        dif;
    logic [12:0] width_reg;

    share_set_t  line_store [MAX_WIDTH];
    share_set_t  win_prev;
    share_set_t  win_cur;
    int          carry_right;
    int          col;
    logic [7:0]  pack;
    int          bitpos;

    out_bytes_t  due_bytes [$];

    function automatic int share_of(input int err, input int k);
        // arithmetic shift floors negative errors
        return (err * k) >>> 4;
    endfunction

    function automatic int clamp_add(input int v, input int c);
        int s;
        s = v + c;
        if (s > 255)
            return 255;
        if (s < 0)
            return 0;
        return s;
    endfunction

    function void wipe_frame();
        for (int i = 0; i < MAX_WIDTH; i++)
            line_store[i] = '0;
        win_prev    = '0;
        win_cur     = '0;
        col         = 0;
        carry_right = 0;
        pack        = '0;
        bitpos      = 0;
    endfunction

    // advance the model by one pixel; returns 1 when a result item leaves
    function bit shade_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic fs, output out_bytes_t res);
        int         w;
        int         x;
        bit         last;
        int         gray;
        int         v;
        int         err;
        bit         mono;
        bit         on;
        bit         px_bit;
        share_set_t s;

        if (fs)
            wipe_frame();

        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        x    = col;
        last = (x + 1 >= w);

        gray = (LUMA_R * int'(r) + LUMA_G * int'(g) + LUMA_B * int'(b)) >>> 16;

        res.byte1   = '0;
        res.byte2   = '0;
        res.count   = 2'd1;
        res.row_end = last;
        if (fmt == FMT_RGB)
        begin
            res.byte0 = r;
            res.byte1 = g;
            res.byte2 = b;
            res.count = 2'd3;
        end
        else
        begin
            res.byte0 = gray[7:0];
        end

        mono = (fmt == FMT_MONO);
        on   = mono && dif;
        s    = line_store[x];
        v    = gray;
        if (on)
        begin
            v = clamp_add(v, s.br);
            v = clamp_add(v, s.bot);
            v = clamp_add(v, s.bl);
            v = clamp_add(v, carry_right);
        end
        px_bit = (v > THRESHOLD);
        err    = on ? v - (px_bit ? 255 : 0) : 0;

        carry_right = last ? 0 : share_of(err, 7);
        if (x > 0)
        begin
            win_prev.bl       = share_of(err, 3);
            line_store[x - 1] = win_prev;
        end
        win_cur.bot = share_of(err, 5);
        if (last)
        begin
            win_cur.bl    = 0;
            line_store[x] = win_cur;
            win_prev      = '0;
            win_cur       = '0;
        end
        else
        begin
            win_prev    = win_cur;
            win_cur.br  = share_of(err, 1);
            win_cur.bot = 0;
            win_cur.bl  = 0;
        end
        col = last ? 0 : x + 1;

        if (!mono)
        begin
            pack   = '0;
            bitpos = 0;
            return 1'b1;
        end

        if (px_bit)
            pack = pack | (8'h80 >> bitpos);
        if (bitpos >= 7 || last)
        begin
            res.byte0 = pack;
            pack      = '0;
            bitpos    = 0;
            return 1'b1;
        end
        bitpos = bitpos + 1;
        return 1'b0;
    endfunction

    function void note_fail(input string text);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
            $display("%t %s", $realtime, text);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_bytes_t made;
        out_bytes_t got;
        out_bytes_t want;

        if (!rst_n)
        begin
            fmt        = FMT_GRAY;
            dif        = 1'b1;
            width_reg  = 13'(DEFAULT_WIDTH);
            fail_count = 0;
            wipe_frame();
            due_bytes.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_OUT_FORMAT:  fmt       = cfg_wdata[1:0];
                    CFG_DIFFUSE:     dif       = cfg_wdata[0];
                    CFG_IMAGE_WIDTH: width_reg = cfg_wdata;
                    default:         ;
                endcase
            end

            if (s_valid && s_ready)
            begin
                if (shade_pixel(s_data[7:0], s_data[15:8], s_data[23:16], s_user, made))
                    due_bytes.push_back(made);
            end

            if (m_valid && m_ready)
            begin
                got = {m_data[7:0], m_data[15:8], m_data[23:16], m_data[25:24], m_last};
                if (due_bytes.size() == 0)
                begin
                    note_fail($sformatf("result item with nothing due: b0=%h b1=%h b2=%h cnt=%0d last=%b",
                                        got.byte0, got.byte1, got.byte2, got.count, got.row_end));
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (got !== want || m_data[31:26] !== 6'd0)
                        note_fail($sformatf({"mismatch: exp b0=%h b1=%h b2=%h cnt=%0d last=%b, ",
                                             "got b0=%h b1=%h b2=%h cnt=%0d last=%b fill=%h"},
                                            want.byte0, want.byte1, want.byte2, want.count,
                                            want.row_end, got.byte0, got.byte1, got.byte2,
                                            got.count, got.row_end, m_data[31:26]));
                end
            end

            pending = due_bytes.size();
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pixels and register writes into the gray / dither / mono packer with
// random gaps and receiver stalls; the checker beside the block predicts and
// compares every result item, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gdmp_pkg::*;
    import gdmp_tb_pkg::*;

    localparam int LIMIT        = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_data;
    logic        s_user;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    logic        m_last;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [12:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycles       = 0;
    int pixels_sent  = 0;
    bit no_idle      = 1'b0;
    bit sink_hold    = 1'b0;
    bit sink_holding = 1'b0;

    gray_dither_mono_packer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    gdmp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .s_user     (s_user),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .m_last     (m_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (no_idle || $urandom_range(0, 99) < 60)
            return 0;
        return idle_len();
    endfunction

    task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic fs);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, g, r};
        s_user  <= fs;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every result item due has left
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver
    initial
    begin
        m_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold)
            begin
                sink_holding = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold    = 1'b0;
                sink_holding = 1'b0;
            end
            else if (no_idle)
            begin
                m_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_ready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                    : $urandom_range(1, 8)) @(posedge clk);
                m_ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // sender
    initial
    begin
        int         base;
        int         n_px;
        int         w_eff;
        int         cur_width;
        int         sel;
        int         tex;
        int         lvl;
        bit         fresh;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;

        s_valid   <= 1'b0;
        s_data    <= '0;
        s_user    <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_OUT_FORMAT;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings after reset: gray bytes, 640 wide
        put_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        put_pixel(8'd255, 8'd0, 8'd0, 1'b0);
        put_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        settle();

        write_reg(CFG_OUT_FORMAT, FMT_RGB);
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        put_pixel(8'd255, 8'd0, 8'd128, 1'b1);
        put_pixel(8'd0, 8'd255, 8'd1, 1'b0);
        put_pixel(8'd170, 8'd85, 8'd255, 1'b0);
        settle();

        // width 0 acts as 1, every pixel ends a row; format 3 gives gray
        write_reg(CFG_OUT_FORMAT, FMT_GRAY_ALT);
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        put_pixel(8'd12, 8'd200, 8'd99, 1'b0);
        put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        settle();

        // mono with diffusion: ramp across the threshold, then a row that
        // takes the errors from above, column 0 included
        write_reg(CFG_OUT_FORMAT, FMT_MONO);
        write_reg(CFG_DIFFUSE, 13'd1);
        write_reg(CFG_IMAGE_WIDTH, 13'd10);
        for (int i = 0; i < 10; i++)
        begin
            lvl = 96 + i * 7;
            put_pixel(lvl[7:0], lvl[7:0], lvl[7:0], i == 0);
        end
        for (int i = 0; i < 4; i++)
            put_pixel({8{i[0]}}, {8{i[0]}}, {8{i[0]}}, 1'b0);
        // new frame drops the partial byte
        put_pixel(8'd140, 8'd140, 8'd140, 1'b1);
        settle();
        write_reg(CFG_SPARE, 13'($urandom));

        // receiver holds off while items keep coming, so the input stalls
        write_reg(CFG_OUT_FORMAT, FMT_RGB);
        write_reg(CFG_IMAGE_WIDTH, 13'd7);
        no_idle   = 1'b1;
        sink_hold = 1'b1;
        wait (sink_holding);
        repeat (40)
            put_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        settle();
        no_idle = 1'b0;

        // widest rows: exact maximum, shrink mid-row, then above maximum
        write_reg(CFG_OUT_FORMAT, FMT_MONO);
        write_reg(CFG_DIFFUSE, 13'd1);
        write_reg(CFG_IMAGE_WIDTH, 13'(MAX_WIDTH));
        for (int i = 0; i < 20; i++)
            put_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 13'd5);
        for (int i = 0; i < 3; i++)
            put_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 13'd8191);
        cur_width = 8191;
        no_idle   = 1'b1;
        for (int i = 0; i < MAX_WIDTH + 40; i++)
            put_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
        settle();
        no_idle = 1'b0;

        base = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 10)
                    write_reg(CFG_OUT_FORMAT, FMT_MONO);
                else if (sel < 13)
                    write_reg(CFG_OUT_FORMAT, FMT_RGB);
                else if (sel < 17)
                    write_reg(CFG_OUT_FORMAT, FMT_GRAY);
                else
                    write_reg(CFG_OUT_FORMAT, FMT_GRAY_ALT);
            end
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_DIFFUSE, 13'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) != 0)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    cur_width = 0;
                else if (sel < 10)
                    cur_width = 1;
                else if (sel < 70)
                    cur_width = $urandom_range(2, 16);
                else if (sel < 92)
                    cur_width = $urandom_range(17, 64);
                else if (sel < 98)
                    cur_width = $urandom_range(65, 300);
                else
                    cur_width = $urandom_range(MAX_WIDTH + 1, 8191);
                write_reg(CFG_IMAGE_WIDTH, 13'(cur_width));
            end
            if ($urandom_range(0, 29) == 0)
                write_reg(CFG_SPARE, 13'($urandom));

            w_eff = (cur_width < 1) ? 1 : ((cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width);
            n_px  = $urandom_range(1, 4) * w_eff;
            if ($urandom_range(0, 1) != 0)
                n_px = n_px + $urandom_range(0, w_eff - 1);
            if (n_px > 600)
                n_px = $urandom_range(50, 600);

            no_idle = ($urandom_range(0, 7) == 0);
            fresh   = ($urandom_range(0, 4) != 0);
            tex     = $urandom_range(0, 4);
            for (int i = 0; i < n_px; i++)
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
                if (tex == 3)
                begin
                    r = {8{r[0]}};
                    g = {8{g[0]}};
                    b = {8{b[0]}};
                end
                else if (tex == 4)
                begin
                    // near the threshold, where diffusion decides the bit
                    lvl = $urandom_range(110, 145);
                    r   = lvl[7:0];
                    g   = lvl[7:0];
                    b   = lvl[7:0];
                end
                // a stray frame start now and then breaks a row
                put_pixel(r, g, b, (i == 0 && fresh) || ($urandom_range(0, 249) == 0));
            end
            settle();
            no_idle = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
